@@ hdl/bds2_pkg.sv @@
// bds2_pkg: shared types and constants of the 2x2 box downsampler
// no dependencies; imported by every other file of the block
`default_nettype none

package bds2_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT    = 4096;

    localparam int PIX_W  = 8;
    localparam int SUM_W  = 9;
    localparam int CHANS  = 4;
    localparam int CFG_DW = 13;
    localparam int CFG_IW = 2;
    localparam int ROW_W  = 12;

    localparam logic [CFG_DW-1:0] WIDTH_RST  = CFG_DW'(4096);
    localparam logic [CFG_DW-1:0] HEIGHT_RST = CFG_DW'(MAX_HEIGHT);
    localparam logic [2:0]        CHAN_RST   = 3'd4;
    localparam logic [2:0]        CHAN_RGB   = 3'd3;

    typedef enum logic [CFG_IW-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_CHANNELS = 2'd2
    } t_cfg_idx;

    typedef logic [CHANS-1:0][PIX_W-1:0] t_pix;
    typedef logic [CHANS-1:0][SUM_W-1:0] t_sums;

    typedef struct packed {
        logic emit;
        logic last;
        logic three;
    } t_ctl;

endpackage

`default_nettype wire

@@ hdl/bds2_in_if.sv @@
// bds2_in_if: input pixel channel, valid/ready with four channel bytes
// depends on bds2_pkg
`default_nettype none

interface bds2_in_if import bds2_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] chan0;
    logic [PIX_W-1:0] chan1;
    logic [PIX_W-1:0] chan2;
    logic [PIX_W-1:0] chan3;

    modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                    input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2, input chan3,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/bds2_out_if.sv @@
// bds2_out_if: output pixel channel, valid/ready with averaged bytes and frame end
// depends on bds2_pkg
`default_nettype none

interface bds2_out_if import bds2_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] avg0;
    logic [PIX_W-1:0] avg1;
    logic [PIX_W-1:0] avg2;
    logic [PIX_W-1:0] avg3;
    logic             frame_last;

    modport source (output valid, output avg0, output avg1, output avg2, output avg3,
                    output frame_last, input ready);
    modport sink   (input valid, input avg0, input avg1, input avg2, input avg3,
                    input frame_last, output ready);
endinterface

`default_nettype wire

@@ hdl/bds2_line_ram.sv @@
// bds2_line_ram: line store of horizontal pair sums, one entry per column pair
// single port, registered read; depends on bds2_pkg
`default_nettype none

module bds2_line_ram import bds2_pkg::*; #(
    parameter int DEPTH = MAX_WIDTH_DEF / 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_addr,
    input  wire t_sums         i_wr_data,
    output t_sums              o_rd_data
);

    t_sums mem [DEPTH];
    t_sums r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hdl/bds2_scan.sv @@
// bds2_scan: config registers, column/row counters, pair hold and pair sums
// drives line store access and stage control; depends on bds2_pkg
`default_nettype none

module bds2_scan import bds2_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int AW        = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_idx,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    input  wire logic              i_accept,
    input  wire t_pix              i_chan,
    output logic                   o_wr_en,
    output logic                   o_rd_en,
    output logic [AW-1:0]          o_addr,
    output t_sums                  o_pair,
    output t_ctl                   o_ctl
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW = (CW + 1 > CFG_DW) ? CW + 1 : CFG_DW;

    logic [CFG_DW-1:0] r_width;
    logic [CFG_DW-1:0] r_height;
    logic [2:0]        r_chans;
    logic [CW-1:0]     r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    t_sums             r_hold, n_hold;

    logic [EW-1:0]     w_eff;
    logic [CFG_DW-1:0] h_eff;
    logic [EW-1:0]     col_ext;
    logic [EW-1:0]     col_inc;
    logic [EW-1:0]     addr_ext;
    logic [CFG_DW-1:0] row_inc;
    logic              three;
    logic              odd_col;
    logic              odd_row;
    t_pix              px;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_chans  <= CHAN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:    r_width  <= i_cfg_data;
                CFG_HEIGHT:   r_height <= i_cfg_data;
                CFG_CHANNELS: r_chans  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            w_eff = EW'(1);
        end else if (EW'(r_width) > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = CFG_DW'(1);
        end else if (r_height > CFG_DW'(MAX_HEIGHT)) begin
            h_eff = CFG_DW'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end

        three   = (r_chans == CHAN_RGB);
        px      = i_chan;
        if (three) begin
            px[3] = '0;
        end

        odd_col  = r_col[0];
        odd_row  = r_row[0];
        col_ext  = EW'(r_col);
        col_inc  = col_ext + EW'(1);
        row_inc  = CFG_DW'(r_row) + CFG_DW'(1);
        addr_ext = (col_ext >> 1) & EW'(LINE_DEPTH - 1);
        o_addr   = addr_ext[AW-1:0];

        for (int k = 0; k < CHANS; k++) begin
            o_pair[k] = r_hold[k] + SUM_W'(px[k]);
        end

        o_ctl.emit  = odd_col & odd_row;
        o_ctl.last  = (col_inc == {w_eff[EW-1:1], 1'b0})
                    && (row_inc == {h_eff[CFG_DW-1:1], 1'b0});
        o_ctl.three = three;

        o_wr_en = i_accept & odd_col & ~odd_row;
        o_rd_en = i_accept & odd_col & odd_row;

        n_hold = r_hold;
        if (!odd_col) begin
            for (int k = 0; k < CHANS; k++) begin
                n_hold[k] = SUM_W'(px[k]);
            end
        end

        n_col = r_col;
        n_row = r_row;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hold <= n_hold;
        end
    end

endmodule

`default_nettype wire

@@ hdl/bds2_avg.sv @@
// bds2_avg: vertical add stage and output register of the downsampler
// takes pair sums and line store data; depends on bds2_pkg, bds2_out_if
`default_nettype none

module bds2_avg import bds2_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_ctl  i_ctl,
    input  wire t_sums i_pair,
    input  wire t_sums i_above,
    output logic       o_free,
    bds2_out_if.source o_avg
);

    logic  r_s1_valid;
    t_sums r_s1_pair;
    logic  r_s1_last;
    logic  r_s1_three;
    logic  r_out_valid;
    t_pix  r_out_avg;
    logic  r_out_last;
    t_pix  n_out_avg;
    logic  out_free;
    logic  [SUM_W:0] tot;

    assign out_free = !r_out_valid || o_avg.ready;
    assign o_free   = !r_s1_valid || out_free;

    always_comb begin
        n_out_avg = '0;
        tot       = '0;
        for (int k = 0; k < CHANS; k++) begin
            tot          = (SUM_W + 1)'(i_above[k]) + (SUM_W + 1)'(r_s1_pair[k]);
            n_out_avg[k] = tot[SUM_W:2];
        end
        if (r_s1_three) begin
            n_out_avg[3] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (o_free) begin
                r_s1_valid <= i_load & i_ctl.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_s1_pair  <= i_pair;
            r_s1_last  <= i_ctl.last;
            r_s1_three <= i_ctl.three;
        end
        if (out_free && r_s1_valid) begin
            r_out_avg  <= n_out_avg;
            r_out_last <= r_s1_last;
        end
    end

    assign o_avg.valid      = r_out_valid;
    assign o_avg.avg0       = r_out_avg[0];
    assign o_avg.avg1       = r_out_avg[1];
    assign o_avg.avg2       = r_out_avg[2];
    assign o_avg.avg3       = r_out_avg[3];
    assign o_avg.frame_last = r_out_last;

endmodule

`default_nettype wire

@@ hdl/box_downsample_2x2.sv @@
// box_downsample_2x2: streaming 2x2 box-filter downsampler, top level
// uses bds2_pkg, bds2_in_if, bds2_out_if, bds2_scan, bds2_line_ram, bds2_avg
//
//   channel  | dir | handshake          | payload
//   i_pix    | in  | valid/ready        | chan0..chan3, 8 bits each
//   o_avg    | out | valid/ready        | avg0..avg3, frame_last
//   i_cfg_*  | in  | write enable only  | 2-bit index, 13-bit data
//
// one input pixel per clock while the add stage is free; the odd-row, odd-column
// pixel of a 2x2 block loads the add stage, whose sum then fills the output register
// the line store is read once and written once per column pair, one port
// synchronous reset clears config, counters and valids; line store is not cleared
// a stalled output holds one result plus one in the add stage before input stalls
`default_nettype none

module box_downsample_2x2 import bds2_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_idx,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    bds2_in_if.sink                i_pix,
    bds2_out_if.source             o_avg
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic          accept;
    logic          s1_free;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] addr;
    t_sums         pair;
    t_sums         above;
    t_ctl          ctl;
    t_pix          chan;

    assign i_pix.ready = i_rst_n & s1_free;
    assign accept      = i_pix.valid & i_pix.ready;
    assign chan        = {i_pix.chan3, i_pix.chan2, i_pix.chan1, i_pix.chan0};

    bds2_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_chan     (chan),
        .o_wr_en    (wr_en),
        .o_rd_en    (rd_en),
        .o_addr     (addr),
        .o_pair     (pair),
        .o_ctl      (ctl)
    );

    bds2_line_ram #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_rd_en   (rd_en),
        .i_addr    (addr),
        .i_wr_data (pair),
        .o_rd_data (above)
    );

    bds2_avg u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_ctl   (ctl),
        .i_pair  (pair),
        .i_above (above),
        .o_free  (s1_free),
        .o_avg   (o_avg)
    );

endmodule

`default_nettype wire

@@ hdl/bds2_check.sv @@
// bds2_check: port-level assertions for box_downsample_2x2, with its bind
// sees only the top level's ports; depends on bds2_pkg
`default_nettype none

module bds2_check import bds2_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [4*PIX_W:0] i_out_data
);

    logic in_xfer;
    assign in_xfer = i_in_valid & i_in_ready;

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a result only follows an earlier input transfer
    a_rise_follows_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_xfer, 2))
        else $error("output appeared without an input transfer");

    // no input transfer while in reset
    a_no_xfer_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |-> !in_xfer)
        else $error("input transfer during reset");

    // stalled result holds its payload
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output changed");

endmodule

bind box_downsample_2x2 bds2_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_avg.valid),
    .i_out_ready (o_avg.ready),
    .i_out_data  ({o_avg.frame_last, o_avg.avg3, o_avg.avg2, o_avg.avg1, o_avg.avg0})
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for box_downsample_2x2, driving pixel streams over valid/ready
// depends on bds2_pkg, bds2_in_if, bds2_out_if and the block's rtl

module tb_top import bds2_pkg::*; ();

    localparam int LINE_PAIRS  = MAX_WIDTH_DEF / 2;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_BUDGET = 1300;

    typedef struct packed {
        t_pix avg;
        logic last;
    } t_box_avg;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    t_cfg_idx          cfg_idx;
    logic [CFG_DW-1:0] cfg_data;

    bds2_in_if  pix_if ();
    bds2_out_if avg_if ();

    box_downsample_2x2 u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_avg      (avg_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state and shadow registers
    logic [CFG_DW-1:0] cfg_width  = WIDTH_RST;
    logic [CFG_DW-1:0] cfg_height = HEIGHT_RST;
    logic [2:0]        cfg_chans  = CHAN_RST;
    int                col_cnt    = 0;
    int                row_cnt    = 0;
    t_sums             pair_hold  = '0;
    t_sums             pair_line [LINE_PAIRS];

    t_pix     pix_q [$];
    t_box_avg avg_q [$];
    t_pix     pix_next;
    t_box_avg avg_want;

    int queued_cnt = 0;
    int sent_cnt;
    int got_cnt;
    int hold_left;
    int hold_mark;
    int cyc = 0;
    int fails = 0;
    bit steady = 1'b0;

    function automatic int clamp_dim(input logic [CFG_DW-1:0] v, input int top);
        if (v == 0) return 1;
        if (v > top) return top;
        return int'(v);
    endfunction

    function automatic void average_block(input t_pix raw);
        t_pix       px;
        t_sums      pair;
        t_sums      above;
        t_box_avg   res;
        logic [9:0] quad;
        int         w;
        int         h;
        int         idx;
        int         k;
        logic       three;
        w = clamp_dim(cfg_width, MAX_WIDTH_DEF);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        three = (cfg_chans == CHAN_RGB);
        px = raw;
        if (three) px[3] = '0;
        if (col_cnt[0] == 1'b0) begin
            for (k = 0; k < CHANS; k++) pair_hold[k] = {1'b0, px[k]};
        end else begin
            idx = (col_cnt >> 1) % LINE_PAIRS;
            for (k = 0; k < CHANS; k++) pair[k] = pair_hold[k] + SUM_W'(px[k]);
            if (row_cnt[0] == 1'b0) begin
                pair_line[idx] = pair;
            end else begin
                above = pair_line[idx];
                for (k = 0; k < CHANS; k++) begin
                    quad = 10'(above[k]) + 10'(pair[k]);
                    res.avg[k] = quad[9:2];
                end
                if (three) res.avg[3] = '0;
                res.last = (col_cnt == (w & ~1) - 1) && (row_cnt == (h & ~1) - 1);
                avg_q.push_back(res);
            end
        end
        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) row_cnt = 0;
        end
    endfunction

    function automatic void cmp_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_if.valid <= 1'b0;
            sent_cnt     <= 0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                average_block({pix_if.chan3, pix_if.chan2, pix_if.chan1, pix_if.chan0});
                sent_cnt <= sent_cnt + 1;
            end
            if (!pix_if.valid || pix_if.ready) begin
                if (pix_q.size() != 0 &&
                    (steady || hold_left != 0 || $urandom_range(99) >= 21)) begin
                    pix_next = pix_q.pop_front();
                    pix_if.valid <= 1'b1;
                    pix_if.chan0 <= pix_next[0];
                    pix_if.chan1 <= pix_next[1];
                    pix_if.chan2 <= pix_next[2];
                    pix_if.chan3 <= pix_next[3];
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and ready generation
    always @(posedge clk) begin
        if (!rst_n) begin
            avg_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_mark    <= -1;
            got_cnt      <= 0;
        end else begin
            if (avg_if.valid && avg_if.ready) begin
                got_cnt <= got_cnt + 1;
                if (avg_q.size() == 0) begin
                    $display("%0t: unexpected output, expected none, actual %0h %0h %0h %0h %b",
                             $time, avg_if.avg0, avg_if.avg1, avg_if.avg2, avg_if.avg3,
                             avg_if.frame_last);
                    fails++;
                end else begin
                    avg_want = avg_q.pop_front();
                    cmp_field("avg0", avg_want.avg[0], avg_if.avg0);
                    cmp_field("avg1", avg_want.avg[1], avg_if.avg1);
                    cmp_field("avg2", avg_want.avg[2], avg_if.avg2);
                    cmp_field("avg3", avg_want.avg[3], avg_if.avg3);
                    cmp_field("frame_last", 8'(avg_want.last), 8'(avg_if.frame_last));
                end
            end
            if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                avg_if.ready <= 1'b0;
            end else if (got_cnt % 700 == 50 && got_cnt != hold_mark) begin
                hold_left    <= HOLD_CYCLES;
                hold_mark    <= got_cnt;
                avg_if.ready <= 1'b0;
            end else begin
                avg_if.ready <= steady || ($urandom_range(99) >= 21);
            end
        end
    end

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("[box_downsample_2x2] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DW-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_WIDTH:    cfg_width  = data;
            CFG_HEIGHT:   cfg_height = data;
            CFG_CHANNELS: cfg_chans  = data[2:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                                input logic [CFG_DW-1:0] c);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_CHANNELS, c);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_px(input logic [7:0] c0, input logic [7:0] c1,
                           input logic [7:0] c2, input logic [7:0] c3);
        pix_q.push_back({c3, c2, c1, c0});
        queued_cnt++;
    endtask

    task automatic push_random(input int count);
        repeat (count) push_px(rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic wait_drained();
        int spin;
        spin = 0;
        while (sent_cnt != queued_cnt) @(posedge clk);
        while (avg_q.size() != 0 && spin < 4000) begin
            @(posedge clk);
            spin++;
        end
        repeat (8) @(posedge clk);
    endtask

    initial begin
        int rand_items;
        int w;
        int h;
        int c;
        int k;
        int reps;
        rand_items = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = CFG_WIDTH;
        cfg_data   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // saturated block and truncation
        set_geometry(4, 2, 4);
        push_px(8'hff, 8'hff, 8'hff, 8'hff);
        push_px(8'hff, 8'hff, 8'hff, 8'hff);
        push_px(8'h01, 8'h02, 8'h03, 8'hfe);
        push_px(8'hff, 8'h00, 8'h80, 8'h7f);
        push_px(8'hff, 8'hff, 8'hff, 8'hff);
        push_px(8'hff, 8'hff, 8'hff, 8'hff);
        push_px(8'h00, 8'hff, 8'h7f, 8'h80);
        push_px(8'h03, 8'h01, 8'h02, 8'h03);
        wait_drained();

        // odd trailing column and row, three channels
        set_geometry(3, 3, 3);
        for (k = 0; k < 9; k++) push_px(8'(k * 29), 8'(255 - k * 29), 8'(k * 7), 8'hff);
        wait_drained();

        // zero width, height and channel count
        set_geometry(0, 0, 0);
        push_px(8'h12, 8'h34, 8'h56, 8'h78);
        push_px(8'hff, 8'hff, 8'hff, 8'hff);
        wait_drained();

        set_geometry(2, 2, 7);
        repeat (4) push_px(8'hff, 8'hff, 8'hff, 8'hff);
        wait_drained();

        // oversized width and height, then shrunk mid-frame
        set_geometry(8191, 8191, 4);
        push_random(64);
        wait_drained();
        set_geometry(8, 2, 4);
        push_random(9);
        wait_drained();

        // long stretch with no idling
        steady = 1'b1;
        set_geometry(64, 6, 3);
        push_random(64 * 6);
        wait_drained();
        steady = 1'b0;

        while (rand_items < 1200) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(25, 100) : $urandom_range(0, 24);
            h = $urandom_range(0, 8);
            c = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : $urandom_range(3, 4);
            k = clamp_dim(CFG_DW'(w), MAX_WIDTH_DEF) * clamp_dim(CFG_DW'(h), MAX_HEIGHT);
            if (k > RAND_BUDGET - rand_items) begin
                w = 2;
                h = 2;
                k = 4;
            end
            reps = $urandom_range(1, 3);
            while (reps > 1 && rand_items + k * reps > RAND_BUDGET) reps--;
            set_geometry(CFG_DW'(w), CFG_DW'(h), CFG_DW'(c));
            push_random(k * reps);
            rand_items += k * reps;
            wait_drained();
        end

        if (avg_q.size() != 0) begin
            $display("%0t: expected %0d more outputs, actual none", $time, avg_q.size());
            fails++;
        end
        if (fails == 0) begin
            $display("[box_downsample_2x2] OK");
        end else begin
            $display("[box_downsample_2x2] ERROR");
        end
        $finish;
    end

endmodule
